@@ rtl/core/lsf_pkg.sv @@
// Shared types and constants for the least-squares line fit block.
package lsf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 16;

    localparam int WIDE       = 128;
    localparam int SUM_BITS   = 32;
    localparam int SQ_BITS    = 48;
    localparam int OUT_BITS   = 48;
    localparam int RATIO_BITS = 17;
    localparam int PCOUNT_BITS = 16;
    localparam int ITER_BITS  = $clog2(WIDE + 2 * FRAC_BITS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic [WIDE-1:0] wide_t;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_FIT   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      go;
        arith_op_t op;
        logic      double_frac;
    } arith_cmd_t;

    typedef struct packed {
        logic add;
        logic clear;
    } acc_cmd_t;

endpackage

@@ rtl/core/least_squares_line_fit.sv @@
// Least-squares line fit: point accumulator, fit sequencer and result registers.
// An item is taken when start is high and busy is low; its result appears for one
// cycle with done high and cannot be stalled. An add item runs three products
// through one 16x16 multiplier; clear and unused kinds, and a calculate item with
// fewer than three points, go straight to done. A full calculate runs 12 multiplies,
// 5 divides and two roots one after another, all on one shared bit-serial unit.
// Every item returns the stored fit results.
module least_squares_line_fit import lsf_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic signed [SAMPLE_BITS-1:0] x_value,
    input  logic signed [SAMPLE_BITS-1:0] y_value,
    output logic                          done,
    output logic signed [OUT_BITS-1:0]    slope,
    output logic signed [OUT_BITS-1:0]    intercept,
    output logic [RATIO_BITS-1:0]         determination,
    output logic [RATIO_BITS-1:0]         correlation,
    output logic [OUT_BITS-1:0]           standard_error,
    output logic [PCOUNT_BITS-1:0]        point_count,
    output logic                          has_data,
    output logic                          degenerate,
    output logic                          dropped
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_ACC,
        T_ISSUE,
        T_WAIT,
        T_DONE
    } top_state_t;

    typedef enum logic [4:0] {
        S_NSXX, S_SXSX, S_NSYY, S_SYSY, S_NSXY, S_SXSY,
        S_SLOPE, S_SXXSY, S_SXSXY, S_ICPT,
        S_N2, S_D, S_DET, S_CORQ, S_COR,
        S_NN2, S_DEN, S_SEQ, S_SE
    } step_t;

    localparam wide_t QUOT_LIM = wide_t'(1) << 62;
    localparam wide_t OUT_HALF = wide_t'(1) << (OUT_BITS - 1);
    localparam wide_t ONE_Q    = wide_t'(1) << FRAC_BITS;
    localparam wide_t ONE_SQ   = wide_t'(1) << (2 * FRAC_BITS);
    localparam wide_t OUT_MAX  = (wide_t'(1) << OUT_BITS) - wide_t'(1);
    localparam logic [COUNT_BITS-1:0] MIN_POINTS = COUNT_BITS'(3);

    top_state_t state_reg;
    step_t      step_reg;
    wide_t      dxx_reg;
    wide_t      dyy_reg;
    wide_t      nxy_reg;
    wide_t      tmp_reg;
    wide_t      n2_reg;
    wide_t      d_reg;
    wide_t      sse_reg;
    logic [OUT_BITS-1:0]   slope_reg;
    logic [OUT_BITS-1:0]   intercept_reg;
    logic [RATIO_BITS-1:0] det_reg;
    logic [RATIO_BITS-1:0] cor_reg;
    logic [OUT_BITS-1:0]   std_reg;
    logic                  degen_reg;
    logic                  dropped_reg;

    acc_cmd_t              acc_cmd;
    logic [COUNT_BITS-1:0] count;
    logic [SUM_BITS-1:0]   sum_x;
    logic [SUM_BITS-1:0]   sum_y;
    logic [SQ_BITS-1:0]    sum_xx;
    logic [SQ_BITS-1:0]    sum_yy;
    logic [SQ_BITS-1:0]    sum_xy;
    logic                  acc_done;

    arith_cmd_t arith_cmd;
    wide_t      op_a;
    wide_t      op_b;
    wide_t      res;
    logic       arith_done;

    logic                   accept;
    logic signed [WIDE-1:0] sx_w;
    logic signed [WIDE-1:0] sy_w;
    logic signed [WIDE-1:0] sxx_w;
    logic signed [WIDE-1:0] syy_w;
    logic signed [WIDE-1:0] sxy_w;
    wide_t                  n_w;
    wide_t                  nm2_w;
    wide_t                  res_diff;
    wide_t                  sse_diff;

    function automatic wide_t mag(input wide_t v);
        return v[WIDE-1] ? (wide_t'(0) - v) : v;
    endfunction

    // Clamp a quotient magnitude, apply sign, saturate to the output width
    function automatic logic [OUT_BITS-1:0] fix_quot(input wide_t q, input logic neg);
        wide_t m;
        m = (q > QUOT_LIM) ? QUOT_LIM : q;
        if (neg)
        begin
            return (m > OUT_HALF) ? OUT_HALF[OUT_BITS-1:0] : (OUT_BITS'(0) - m[OUT_BITS-1:0]);
        end
        return (m >= OUT_HALF) ? OUT_BITS'(OUT_HALF - wide_t'(1)) : m[OUT_BITS-1:0];
    endfunction

    assign accept = start && !busy;
    assign sx_w   = WIDE'($signed(sum_x));
    assign sy_w   = WIDE'($signed(sum_y));
    assign sxx_w  = WIDE'($signed(sum_xx));
    assign syy_w  = WIDE'($signed(sum_yy));
    assign sxy_w  = WIDE'($signed(sum_xy));
    assign n_w    = WIDE'(count);
    assign nm2_w  = WIDE'(count - COUNT_BITS'(2));
    assign res_diff = tmp_reg - res;
    assign sse_diff = res - n2_reg;

    // Drive the accumulator straight from an accepted item
    always_comb
    begin
        acc_cmd.add   = accept && (kind_t'(kind) == KIND_ADD) && (count != COUNT_MAX);
        acc_cmd.clear = accept && (kind_t'(kind) == KIND_CLEAR);
    end

    lsf_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (acc_cmd),
        .x_in   (x_value),
        .y_in   (y_value),
        .count  (count),
        .sum_x  (sum_x),
        .sum_y  (sum_y),
        .sum_xx (sum_xx),
        .sum_yy (sum_yy),
        .sum_xy (sum_xy),
        .done   (acc_done)
    );

    // Select operation and operands for the current fit step
    always_comb
    begin
        arith_cmd.go          = (state_reg == T_ISSUE);
        arith_cmd.op          = OP_MUL;
        arith_cmd.double_frac = 1'b0;
        op_a                  = '0;
        op_b                  = '0;
        case (step_reg)
            S_NSXX:  begin op_a = n_w;  op_b = sxx_w; end
            S_SXSX:  begin op_a = sx_w; op_b = sx_w;  end
            S_NSYY:  begin op_a = n_w;  op_b = syy_w; end
            S_SYSY:  begin op_a = sy_w; op_b = sy_w;  end
            S_NSXY:  begin op_a = n_w;  op_b = sxy_w; end
            S_SXSY:  begin op_a = sx_w; op_b = sy_w;  end
            S_SLOPE:
            begin
                arith_cmd.op = OP_DIV;
                op_a         = mag(nxy_reg);
                op_b         = mag(dxx_reg);
            end
            S_SXXSY: begin op_a = sxx_w; op_b = sy_w;  end
            S_SXSXY: begin op_a = sx_w;  op_b = sxy_w; end
            S_ICPT:
            begin
                arith_cmd.op = OP_DIV;
                op_a         = mag(tmp_reg);
                op_b         = mag(dxx_reg);
            end
            S_N2:    begin op_a = nxy_reg; op_b = nxy_reg; end
            S_D:     begin op_a = dxx_reg; op_b = dyy_reg; end
            S_DET:
            begin
                arith_cmd.op = OP_DIV;
                op_a         = n2_reg;
                op_b         = d_reg;
            end
            S_CORQ:
            begin
                arith_cmd.op          = OP_DIV;
                arith_cmd.double_frac = 1'b1;
                op_a                  = n2_reg;
                op_b                  = d_reg;
            end
            S_COR:
            begin
                arith_cmd.op = OP_SQRT;
                op_a         = tmp_reg;
            end
            S_NN2:   begin op_a = n_w;     op_b = nm2_w;   end
            S_DEN:   begin op_a = tmp_reg; op_b = dxx_reg; end
            S_SEQ:
            begin
                arith_cmd.op          = OP_DIV;
                arith_cmd.double_frac = 1'b1;
                op_a                  = sse_reg;
                op_b                  = tmp_reg;
            end
            S_SE:
            begin
                arith_cmd.op = OP_SQRT;
                op_a         = tmp_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    lsf_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (arith_cmd),
        .a      (op_a),
        .b      (op_b),
        .result (res),
        .done   (arith_done)
    );

    // Sequence items and fit steps, hold stored results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            step_reg      <= S_NSXX;
            slope_reg     <= '0;
            intercept_reg <= '0;
            det_reg       <= '0;
            cor_reg       <= '0;
            std_reg       <= '0;
            degen_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        dropped_reg <= 1'b0;
                        state_reg   <= T_DONE;
                        case (kind_t'(kind))
                            KIND_ADD:
                            begin
                                if (count == COUNT_MAX)
                                begin
                                    dropped_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= T_ACC;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                slope_reg     <= '0;
                                intercept_reg <= '0;
                                det_reg       <= '0;
                                cor_reg       <= '0;
                                std_reg       <= '0;
                                degen_reg     <= 1'b0;
                            end
                            KIND_FIT:
                            begin
                                if (count >= MIN_POINTS)
                                begin
                                    step_reg  <= S_NSXX;
                                    state_reg <= T_ISSUE;
                                end
                            end
                            default:
                            begin
                                state_reg <= T_DONE;
                            end
                        endcase
                    end
                end
                T_ACC:
                begin
                    if (acc_done)
                    begin
                        state_reg <= T_DONE;
                    end
                end
                T_ISSUE:
                begin
                    state_reg <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (arith_done)
                    begin
                        state_reg <= T_ISSUE;
                        case (step_reg)
                            S_NSXX:  begin tmp_reg <= res;      step_reg <= S_SXSX; end
                            S_SXSX:  begin dxx_reg <= res_diff; step_reg <= S_NSYY; end
                            S_NSYY:  begin tmp_reg <= res;      step_reg <= S_SYSY; end
                            S_SYSY:  begin dyy_reg <= res_diff; step_reg <= S_NSXY; end
                            S_NSXY:  begin tmp_reg <= res;      step_reg <= S_SXSY; end
                            S_SXSY:
                            begin
                                nxy_reg <= res_diff;
                                step_reg <= S_SLOPE;
                                // Zero x spread: zero every result
                                if (dxx_reg == '0)
                                begin
                                    slope_reg     <= '0;
                                    intercept_reg <= '0;
                                    det_reg       <= '0;
                                    cor_reg       <= '0;
                                    std_reg       <= '0;
                                    degen_reg     <= 1'b1;
                                    state_reg     <= T_DONE;
                                end
                            end
                            S_SLOPE:
                            begin
                                slope_reg <= fix_quot(res, nxy_reg[WIDE-1] ^ dxx_reg[WIDE-1]);
                                step_reg  <= S_SXXSY;
                            end
                            S_SXXSY: begin tmp_reg <= res;      step_reg <= S_SXSXY; end
                            S_SXSXY: begin tmp_reg <= res_diff; step_reg <= S_ICPT;  end
                            S_ICPT:
                            begin
                                intercept_reg <= fix_quot(res, tmp_reg[WIDE-1] ^ dxx_reg[WIDE-1]);
                                step_reg      <= S_N2;
                            end
                            S_N2:    begin n2_reg <= res; step_reg <= S_D; end
                            S_D:
                            begin
                                d_reg   <= res;
                                sse_reg <= sse_diff[WIDE-1] ? '0 : sse_diff;
                                // Flat y series: no determination or correlation
                                if (res == '0)
                                begin
                                    det_reg   <= '0;
                                    cor_reg   <= '0;
                                    degen_reg <= 1'b1;
                                    step_reg  <= S_NN2;
                                end
                                else
                                begin
                                    step_reg <= S_DET;
                                end
                            end
                            S_DET:
                            begin
                                det_reg  <= (res > ONE_Q) ? RATIO_BITS'(ONE_Q) : res[RATIO_BITS-1:0];
                                step_reg <= S_CORQ;
                            end
                            S_CORQ:
                            begin
                                tmp_reg  <= (res > ONE_SQ) ? ONE_SQ : res;
                                step_reg <= S_COR;
                            end
                            S_COR:
                            begin
                                cor_reg   <= res[RATIO_BITS-1:0];
                                degen_reg <= 1'b0;
                                step_reg  <= S_NN2;
                            end
                            S_NN2:   begin tmp_reg <= res; step_reg <= S_DEN; end
                            S_DEN:
                            begin
                                tmp_reg  <= res;
                                step_reg <= S_SEQ;
                                if (res == '0)
                                begin
                                    std_reg   <= '0;
                                    state_reg <= T_DONE;
                                end
                            end
                            S_SEQ:   begin tmp_reg <= res; step_reg <= S_SE; end
                            S_SE:
                            begin
                                std_reg   <= (res > OUT_MAX) ? '1 : res[OUT_BITS-1:0];
                                state_reg <= T_DONE;
                            end
                            default:
                            begin
                                state_reg <= T_DONE;
                            end
                        endcase
                    end
                end
                T_DONE:
                begin
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != T_IDLE);
    assign done           = (state_reg == T_DONE);
    assign slope          = slope_reg;
    assign intercept      = intercept_reg;
    assign determination  = det_reg;
    assign correlation    = cor_reg;
    assign standard_error = std_reg;
    assign point_count    = PCOUNT_BITS'(count);
    assign has_data       = (count > COUNT_BITS'(2));
    assign degenerate     = degen_reg;
    assign dropped        = dropped_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done not followed by idle");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped |-> (count == COUNT_MAX))
        else $error("drop flagged below full count");

    a_arith_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        arith_done |-> (state_reg == T_WAIT))
        else $error("arithmetic result outside fit wait");

endmodule

@@ rtl/core/lsf_accum.sv @@
// Point accumulator: count and running sums with one shared small multiplier.
module lsf_accum import lsf_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  acc_cmd_t                      cmd,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [SAMPLE_BITS-1:0] y_in,
    output logic [COUNT_BITS-1:0]         count,
    output logic [SUM_BITS-1:0]           sum_x,
    output logic [SUM_BITS-1:0]           sum_y,
    output logic [SQ_BITS-1:0]            sum_xx,
    output logic [SQ_BITS-1:0]            sum_yy,
    output logic [SQ_BITS-1:0]            sum_xy,
    output logic                          done
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_XX,
        A_YY,
        A_XY
    } acc_state_t;

    acc_state_t                    state_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic [SUM_BITS-1:0]           sum_x_reg;
    logic [SUM_BITS-1:0]           sum_y_reg;
    logic [SQ_BITS-1:0]            sum_xx_reg;
    logic [SQ_BITS-1:0]            sum_yy_reg;
    logic [SQ_BITS-1:0]            sum_xy_reg;
    logic                          done_reg;

    logic signed [SAMPLE_BITS-1:0]   mul_a;
    logic signed [SAMPLE_BITS-1:0]   mul_b;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic signed [SQ_BITS-1:0]       prod_ext;
    logic signed [SUM_BITS-1:0]      x_ext;
    logic signed [SUM_BITS-1:0]      y_ext;

    // Pick multiplier operands for the current product
    always_comb
    begin
        mul_a = x_reg;
        mul_b = x_reg;
        case (state_reg)
            A_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            A_XY:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = SQ_BITS'(prod);
    assign x_ext    = SUM_BITS'(x_in);
    assign y_ext    = SUM_BITS'(y_in);

    // Advance the accumulate sequence, one product per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= A_IDLE;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (cmd.clear)
                    begin
                        count_reg  <= '0;
                        sum_x_reg  <= '0;
                        sum_y_reg  <= '0;
                        sum_xx_reg <= '0;
                        sum_yy_reg <= '0;
                        sum_xy_reg <= '0;
                    end
                    else if (cmd.add)
                    begin
                        x_reg     <= x_in;
                        y_reg     <= y_in;
                        count_reg <= count_reg + COUNT_BITS'(1);
                        sum_x_reg <= sum_x_reg + x_ext;
                        sum_y_reg <= sum_y_reg + y_ext;
                        state_reg <= A_XX;
                    end
                end
                A_XX:
                begin
                    sum_xx_reg <= sum_xx_reg + prod_ext;
                    state_reg  <= A_YY;
                end
                A_YY:
                begin
                    sum_yy_reg <= sum_yy_reg + prod_ext;
                    state_reg  <= A_XY;
                end
                A_XY:
                begin
                    sum_xy_reg <= sum_xy_reg + prod_ext;
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign count  = count_reg;
    assign sum_x  = sum_x_reg;
    assign sum_y  = sum_y_reg;
    assign sum_xx = sum_xx_reg;
    assign sum_yy = sum_yy_reg;
    assign sum_xy = sum_xy_reg;
    assign done   = done_reg;

endmodule

@@ rtl/core/lsf_arith.sv @@
// Shared iterative unit: wide multiply, restoring divide and integer square root.
module lsf_arith import lsf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  arith_cmd_t cmd,
    input  wide_t      a,
    input  wide_t      b,
    output wide_t      result,
    output logic       done
);

    typedef enum logic [1:0] {
        R_IDLE,
        R_MUL,
        R_DIV,
        R_SQRT
    } arith_state_t;

    localparam wide_t SQRT_TOP = wide_t'(1) << (WIDE - 2);

    arith_state_t         state_reg;
    wide_t                acc_reg;
    wide_t                x_reg;
    wide_t                y_reg;
    wide_t                den_reg;
    logic [ITER_BITS-1:0] cnt_reg;
    logic [ITER_BITS-1:0] last_reg;
    logic                 sat_reg;
    logic                 done_reg;

    logic [WIDE:0] div_shift;
    logic [WIDE:0] div_diff;
    wide_t         sq_trial;
    logic [WIDE:0] sq_diff;
    wide_t         sq_half;

    // Divide step: shift in next dividend bit, trial subtract
    assign div_shift = {x_reg, y_reg[WIDE-1]};
    assign div_diff  = div_shift - {1'b0, den_reg};

    // Root step: compare remainder against root plus current bit
    assign sq_trial = acc_reg + y_reg;
    assign sq_diff  = {1'b0, x_reg} - {1'b0, sq_trial};
    assign sq_half  = acc_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
            last_reg  <= '0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                R_IDLE:
                begin
                    if (cmd.go)
                    begin
                        cnt_reg <= '0;
                        sat_reg <= 1'b0;
                        acc_reg <= '0;
                        case (cmd.op)
                            OP_MUL:
                            begin
                                x_reg     <= a;
                                y_reg     <= b;
                                last_reg  <= ITER_BITS'(WIDE - 1);
                                state_reg <= R_MUL;
                            end
                            OP_DIV:
                            begin
                                x_reg     <= '0;
                                y_reg     <= a;
                                den_reg   <= b;
                                last_reg  <= cmd.double_frac ?
                                             ITER_BITS'(WIDE + 2 * FRAC_BITS - 1) :
                                             ITER_BITS'(WIDE + FRAC_BITS - 1);
                                state_reg <= R_DIV;
                            end
                            OP_SQRT:
                            begin
                                x_reg     <= a;
                                y_reg     <= SQRT_TOP;
                                last_reg  <= ITER_BITS'(WIDE / 2 - 1);
                                state_reg <= R_SQRT;
                            end
                            default:
                            begin
                                state_reg <= R_IDLE;
                            end
                        endcase
                    end
                end
                R_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_reg <= acc_reg + x_reg;
                    end
                    x_reg   <= x_reg << 1;
                    y_reg   <= y_reg >> 1;
                    cnt_reg <= cnt_reg + ITER_BITS'(1);
                    if (cnt_reg == last_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                end
                R_DIV:
                begin
                    sat_reg <= sat_reg | acc_reg[WIDE-1];
                    acc_reg <= {acc_reg[WIDE-2:0], ~div_diff[WIDE]};
                    x_reg   <= div_diff[WIDE] ? div_shift[WIDE-1:0] : div_diff[WIDE-1:0];
                    y_reg   <= y_reg << 1;
                    cnt_reg <= cnt_reg + ITER_BITS'(1);
                    if (cnt_reg == last_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                end
                R_SQRT:
                begin
                    if (!sq_diff[WIDE])
                    begin
                        x_reg   <= sq_diff[WIDE-1:0];
                        acc_reg <= sq_half + y_reg;
                    end
                    else
                    begin
                        acc_reg <= sq_half;
                    end
                    y_reg   <= y_reg >> 2;
                    cnt_reg <= cnt_reg + ITER_BITS'(1);
                    if (cnt_reg == last_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    // Quotient overflow reads as all ones
    assign result = sat_reg ? '1 : acc_reg;
    assign done   = done_reg;

endmodule
